// File: hdl/sipf_pkg.sv
// ----------------------------------------------------------------------------
// Servo instruction packet framer package
// Shared types, codes and constants for the packet framer modules.
// ----------------------------------------------------------------------------
package sipf_pkg;

   localparam int DEF_MAX_DATA_BYTES = 4;
   localparam int DATA_FIELDS        = 4;
   localparam int BODY_BYTES         = 4 + DATA_FIELDS;
   localparam int BODY_IDX_W         = $clog2(BODY_BYTES);
   localparam int POS_W              = $clog2(BODY_BYTES + 3);
   localparam int HEADER_BYTES       = 2;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_RESET = 2'd2;

   localparam logic [7:0] PKT_START = 8'hFF;
   localparam logic [7:0] INS_READ  = 8'h02;
   localparam logic [7:0] INS_WRITE = 8'h03;
   localparam logic [7:0] INS_RESET = 8'h06;
   localparam logic [7:0] RESET_LEN = 8'h02;
   localparam logic [7:0] READ_LEN  = 8'h04;
   localparam logic [7:0] WRITE_LEN_BASE = 8'h03;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] target_id;
      logic [7:0] reg_addr;
      logic [2:0] data_count;
      logic [7:0] data_byte0;
      logic [7:0] data_byte1;
      logic [7:0] data_byte2;
      logic [7:0] data_byte3;
      logic [7:0] read_length;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
   } rsp_type;

   typedef struct packed {
      logic [BODY_BYTES-1:0][7:0] body;
      logic [7:0]                 checksum;
      logic [POS_W-1:0]           last_pos;
   } desc_type;

endpackage

// File: hdl/sipf_front.sv
// ----------------------------------------------------------------------------
// Packet framer front end
// Accepts commands, builds the packet body and checksum, and hands the
// finished descriptor to the command queue.
// ----------------------------------------------------------------------------
module sipf_front #(
   parameter int MAX_DATA_BYTES = sipf_pkg::DEF_MAX_DATA_BYTES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  sipf_pkg::req_type  req_data,
   output logic               q_push,
   input  logic               q_full,
   output sipf_pkg::desc_type q_data
);

   localparam int EFF_MAX = (MAX_DATA_BYTES < sipf_pkg::DATA_FIELDS) ?
                            MAX_DATA_BYTES : sipf_pkg::DATA_FIELDS;
   localparam logic [2:0] EFF_MAX_3 = 3'(EFF_MAX);

   logic               f_valid_ff, f_valid_in;
   sipf_pkg::desc_type f_desc_ff, f_desc_in;
   logic               accept;
   logic [2:0]         n_bytes;
   logic [7:0]         data_in [sipf_pkg::DATA_FIELDS];
   logic [7:0]         sum;
   logic               cmd_ok;

   assign req_full = f_valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_push   = f_valid_ff && !q_full;
   assign q_data   = f_desc_ff;

   assign data_in[0] = req_data.data_byte0;
   assign data_in[1] = req_data.data_byte1;
   assign data_in[2] = req_data.data_byte2;
   assign data_in[3] = req_data.data_byte3;

   always_comb begin
      n_bytes   = (req_data.data_count > EFF_MAX_3) ? EFF_MAX_3 : req_data.data_count;
      f_desc_in = '0;
      cmd_ok    = 1'b1;
      f_desc_in.body[0] = req_data.target_id;
      unique case (req_data.func)
         sipf_pkg::FUNC_WRITE: begin
            f_desc_in.body[1] = sipf_pkg::WRITE_LEN_BASE + 8'(n_bytes);
            f_desc_in.body[2] = sipf_pkg::INS_WRITE;
            f_desc_in.body[3] = req_data.reg_addr;
            for (int i = 0; i < sipf_pkg::DATA_FIELDS; i++) begin
               if (3'(i) < n_bytes) begin
                  f_desc_in.body[4 + i] = data_in[i];
               end
            end
            f_desc_in.last_pos = sipf_pkg::POS_W'(sipf_pkg::HEADER_BYTES + 4)
                                 + sipf_pkg::POS_W'(n_bytes);
         end
         sipf_pkg::FUNC_READ: begin
            f_desc_in.body[1] = sipf_pkg::READ_LEN;
            f_desc_in.body[2] = sipf_pkg::INS_READ;
            f_desc_in.body[3] = req_data.reg_addr;
            f_desc_in.body[4] = req_data.read_length;
            f_desc_in.last_pos = sipf_pkg::POS_W'(sipf_pkg::HEADER_BYTES + 5);
         end
         sipf_pkg::FUNC_RESET: begin
            f_desc_in.body[1] = sipf_pkg::RESET_LEN;
            f_desc_in.body[2] = sipf_pkg::INS_RESET;
            f_desc_in.last_pos = sipf_pkg::POS_W'(sipf_pkg::HEADER_BYTES + 3);
         end
         default: begin
            cmd_ok = 1'b0;
         end
      endcase
      sum = '0;
      for (int i = 0; i < sipf_pkg::BODY_BYTES; i++) begin
         sum = sum + f_desc_in.body[i];
      end
      f_desc_in.checksum = ~sum;
   end

   always_comb begin
      if (accept) begin
         f_valid_in = cmd_ok;
      end else if (q_push) begin
         f_valid_in = 1'b0;
      end else begin
         f_valid_in = f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_desc_ff <= f_desc_in;
      end
   end

endmodule

// File: hdl/sipf_cmd_queue.sv
// ----------------------------------------------------------------------------
// Packet framer command queue
// Short register queue of packet descriptors between front and back end.
// ----------------------------------------------------------------------------
module sipf_cmd_queue #(
   parameter int DEPTH = sipf_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  sipf_pkg::desc_type wr_data,
   output logic               full,
   input  logic               rd_en,
   output sipf_pkg::desc_type rd_data,
   output logic               empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   sipf_pkg::desc_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr, do_rd;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: hdl/sipf_back.sv
// ----------------------------------------------------------------------------
// Packet framer back end
// Serializes one packet descriptor at a time into wire bytes through an
// output register.
// ----------------------------------------------------------------------------
module sipf_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  sipf_pkg::desc_type q_data,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output sipf_pkg::rsp_type  rsp_data
);

   logic                         busy_ff, busy_in;
   logic [sipf_pkg::POS_W-1:0]   pos_ff, pos_in;
   sipf_pkg::desc_type           desc_ff;
   logic                         out_valid_ff, out_valid_in;
   sipf_pkg::rsp_type            out_ff, out_in;
   logic                         advance, at_end, take;
   logic [sipf_pkg::POS_W-1:0]   body_pos;
   logic [sipf_pkg::BODY_IDX_W-1:0] body_idx;

   assign advance   = busy_ff && (!out_valid_ff || rsp_pop);
   assign at_end    = (pos_ff == desc_ff.last_pos);
   assign take      = !q_empty && (!busy_ff || (advance && at_end));
   assign q_pop     = take;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign body_pos  = pos_ff - sipf_pkg::POS_W'(sipf_pkg::HEADER_BYTES);
   assign body_idx  = body_pos[sipf_pkg::BODY_IDX_W-1:0];

   always_comb begin
      out_in = out_ff;
      if (advance) begin
         out_in.last_byte = at_end;
         if (pos_ff < sipf_pkg::POS_W'(sipf_pkg::HEADER_BYTES)) begin
            out_in.tx_byte = sipf_pkg::PKT_START;
         end else if (at_end) begin
            out_in.tx_byte = desc_ff.checksum;
         end else begin
            out_in.tx_byte = desc_ff.body[body_idx];
         end
      end
   end

   always_comb begin
      if (take) begin
         busy_in = 1'b1;
         pos_in  = '0;
      end else if (advance) begin
         busy_in = !at_end;
         pos_in  = pos_ff + 1'b1;
      end else begin
         busy_in = busy_ff;
         pos_in  = pos_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         desc_ff <= q_data;
      end
      out_ff <= out_in;
   end

   a_pos_in_packet: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pos_ff <= desc_ff.last_pos))
      else $error("byte position beyond end of packet");

   a_take_restarts: assert property (@(posedge clock) disable iff (reset)
      take |=> (busy_ff && pos_ff == '0))
      else $error("new packet did not start at its first byte");

   a_packet_length: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (desc_ff.last_pos >= sipf_pkg::POS_W'(5) &&
                   desc_ff.last_pos <= sipf_pkg::POS_W'(10)))
      else $error("packet descriptor has an impossible length");

   a_last_ends_packet: assert property (@(posedge clock) disable iff (reset)
      (advance && at_end && !take) |=> !busy_ff)
      else $error("back end still busy after the checksum byte");

endmodule

// File: hdl/servo_instruction_packet_framer_core.sv
// ----------------------------------------------------------------------------
// Servo instruction packet framer
// Turns servo commands into serial instruction packets, one byte per item.
//
// Commands enter through req_push/req_full and req_data; an item is taken
// when req_push is high and req_full is low. Wire bytes leave through
// rsp_empty/rsp_pop and rsp_data; the oldest byte is shown while rsp_empty
// is low and is taken when rsp_pop is high. last_byte marks the checksum.
// A reset command gives 6 bytes, a read 8 and a write 7 to 11 bytes.
// Command kind 3 is dropped and yields no bytes.
// A command passes the front-end register, the descriptor queue and the
// back-end descriptor register before its first byte enters the output
// register. The back end sends one byte per cycle while the receiver pops,
// with no gaps between packets. A two-entry descriptor queue lets new
// commands enter while a packet is still being sent. When the receiver
// stops popping, the output register holds its byte and the queue fills,
// after which req_full rises. Synchronous reset empties every stage.
// ----------------------------------------------------------------------------
module servo_instruction_packet_framer_core #(
   parameter int MAX_DATA_BYTES = sipf_pkg::DEF_MAX_DATA_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  sipf_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output sipf_pkg::rsp_type rsp_data
);

   logic               q_push, q_full, q_pop, q_empty;
   sipf_pkg::desc_type q_wr_data, q_rd_data;

   sipf_front #(
      .MAX_DATA_BYTES(MAX_DATA_BYTES)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .q_push  (q_push),
      .q_full  (q_full),
      .q_data  (q_wr_data)
   );

   sipf_cmd_queue #(
      .DEPTH(sipf_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (q_push),
      .wr_data(q_wr_data),
      .full   (q_full),
      .rd_en  (q_pop),
      .rd_data(q_rd_data),
      .empty  (q_empty)
   );

   sipf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_rd_data),
      .q_pop    (q_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

endmodule

// File: verif/servo_instruction_packet_framer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo instruction packet framer testbench
// Sends write, read, reset and undefined commands into the framer. A
// scoreboard builds the expected wire bytes of every accepted command and
// compares each popped byte against them. Both sides idle at random, and
// the receiver stalls once for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------
module servo_instruction_packet_framer_core_tb;

   localparam int         MAX_BYTES    = sipf_pkg::DEF_MAX_DATA_BYTES;
   localparam logic [1:0] FUNC_UNUSED  = 2'd3;
   localparam int         RANDOM_CMDS  = 330;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         HOLD_AFTER   = 100;
   localparam int         DRAIN_CYCLES = 20;
   localparam int         IDLE_LIMIT   = 3000;

   class packet_scoreboard;
      sipf_pkg::rsp_type wire_q[$];
      int                errors;
      int                n_write;
      int                n_read;
      int                n_reset;
      int                n_dropped;
      int                n_bytes;

      function int n_cmds();
         return n_write + n_read + n_reset;
      endfunction

      function void note_command(sipf_pkg::req_type c);
         logic [7:0] body[$];
         logic [7:0] data[sipf_pkg::DATA_FIELDS];
         logic [7:0] sum;
         int         n;
         data[0] = c.data_byte0;
         data[1] = c.data_byte1;
         data[2] = c.data_byte2;
         data[3] = c.data_byte3;
         case (c.func)
            sipf_pkg::FUNC_WRITE: begin
               n = c.data_count;
               if (n > MAX_BYTES) n = MAX_BYTES;
               if (n > sipf_pkg::DATA_FIELDS) n = sipf_pkg::DATA_FIELDS;
               body.push_back(sipf_pkg::WRITE_LEN_BASE + 8'(n));
               body.push_back(sipf_pkg::INS_WRITE);
               body.push_back(c.reg_addr);
               for (int i = 0; i < n; i++) body.push_back(data[i]);
               n_write++;
            end
            sipf_pkg::FUNC_READ: begin
               body.push_back(sipf_pkg::READ_LEN);
               body.push_back(sipf_pkg::INS_READ);
               body.push_back(c.reg_addr);
               body.push_back(c.read_length);
               n_read++;
            end
            sipf_pkg::FUNC_RESET: begin
               body.push_back(sipf_pkg::RESET_LEN);
               body.push_back(sipf_pkg::INS_RESET);
               n_reset++;
            end
            default: begin
               n_dropped++;
               return;
            end
         endcase
         sum = c.target_id;
         foreach (body[i]) sum += body[i];
         wire_q.push_back('{tx_byte: sipf_pkg::PKT_START, last_byte: 1'b0});
         wire_q.push_back('{tx_byte: sipf_pkg::PKT_START, last_byte: 1'b0});
         wire_q.push_back('{tx_byte: c.target_id, last_byte: 1'b0});
         foreach (body[i]) wire_q.push_back('{tx_byte: body[i], last_byte: 1'b0});
         wire_q.push_back('{tx_byte: ~sum, last_byte: 1'b1});
      endfunction

      function void check_byte(sipf_pkg::rsp_type got);
         sipf_pkg::rsp_type want;
         n_bytes++;
         if (wire_q.size() == 0) begin
            $error("Unexpected byte: tx_byte %02h, last_byte %0b", got.tx_byte, got.last_byte);
            errors++;
            return;
         end
         want = wire_q.pop_front();
         if (got.tx_byte !== want.tx_byte) begin
            $error("tx_byte: expected %02h, actual %02h", want.tx_byte, got.tx_byte);
            errors++;
         end
         if (got.last_byte !== want.last_byte) begin
            $error("last_byte: expected %0b, actual %0b", want.last_byte, got.last_byte);
            errors++;
         end
      endfunction
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_push  = 1'b0;
   logic              req_full;
   sipf_pkg::req_type req_data  = '0;
   logic              rsp_empty;
   logic              rsp_pop   = 1'b0;
   sipf_pkg::rsp_type rsp_data;

   packet_scoreboard sb = new();
   bit tx_steady = 1'b0;
   bit hold_done = 1'b0;

   servo_instruction_packet_framer_core #(
      .MAX_DATA_BYTES(MAX_BYTES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic sipf_pkg::req_type make_cmd(logic [1:0] f, logic [7:0] id,
                                                  logic [7:0] addr, logic [2:0] n,
                                                  logic [7:0] d0, logic [7:0] d1,
                                                  logic [7:0] d2, logic [7:0] d3,
                                                  logic [7:0] rlen);
      sipf_pkg::req_type c;
      c.func        = f;
      c.target_id   = id;
      c.reg_addr    = addr;
      c.data_count  = n;
      c.data_byte0  = d0;
      c.data_byte1  = d1;
      c.data_byte2  = d2;
      c.data_byte3  = d3;
      c.read_length = rlen;
      return c;
   endfunction

   task automatic send_command(sipf_pkg::req_type c);
      int gap;
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= c;
      do @(posedge clock); while (req_full);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) sb.note_command(req_data);
         if (rsp_pop && !rsp_empty) sb.check_byte(rsp_data);
      end
   end

   initial begin : receiver
      int gap;
      int run;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!hold_done && sb.n_cmds() >= HOLD_AFTER) begin
            rsp_pop <= 1'b0;
            for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clock);
            hold_done = 1'b1;
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         run = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 20);
         repeat (run) @(posedge clock);
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle = 0;
         else idle++;
      end
      $error("No item moved for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      sipf_pkg::req_type c;
      int                sent;
      int                r;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_command(make_cmd(sipf_pkg::FUNC_WRITE, 8'h00, 8'h00, 3'd0,
                            8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_command(make_cmd(sipf_pkg::FUNC_WRITE, 8'hFE, 8'hFF, 3'd1,
                            8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
      send_command(make_cmd(sipf_pkg::FUNC_WRITE, 8'h01, 8'h1E, 3'd2,
                            8'hAA, 8'h55, 8'h00, 8'h00, 8'h00));
      send_command(make_cmd(sipf_pkg::FUNC_WRITE, 8'h12, 8'h20, 3'd3,
                            8'h01, 8'h02, 8'h03, 8'hFF, 8'h00));
      send_command(make_cmd(sipf_pkg::FUNC_WRITE, 8'hFE, 8'hFF, 3'd4,
                            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00));
      send_command(make_cmd(sipf_pkg::FUNC_WRITE, 8'h05, 8'h18, 3'd5,
                            8'h11, 8'h22, 8'h33, 8'h44, 8'h00));
      send_command(make_cmd(sipf_pkg::FUNC_WRITE, 8'h06, 8'h19, 3'd6,
                            8'h80, 8'h7F, 8'h01, 8'hFE, 8'hFF));
      send_command(make_cmd(sipf_pkg::FUNC_WRITE, 8'hFE, 8'hFF, 3'd7,
                            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_command(make_cmd(sipf_pkg::FUNC_READ, 8'h00, 8'h00, 3'd0,
                            8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_command(make_cmd(sipf_pkg::FUNC_READ, 8'hFE, 8'hFF, 3'd7,
                            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_command(make_cmd(sipf_pkg::FUNC_READ, 8'h01, 8'h80, 3'd4,
                            8'h12, 8'h34, 8'h56, 8'h78, 8'h01));
      send_command(make_cmd(sipf_pkg::FUNC_RESET, 8'h00, 8'hFF, 3'd7,
                            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_command(make_cmd(sipf_pkg::FUNC_RESET, 8'hFE, 8'h00, 3'd0,
                            8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_command(make_cmd(sipf_pkg::FUNC_RESET, 8'hF9, 8'h5A, 3'd2,
                            8'hA5, 8'h5A, 8'hA5, 8'h5A, 8'hC3));
      send_command(make_cmd(FUNC_UNUSED, 8'hFE, 8'hFF, 3'd7,
                            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_command(make_cmd(sipf_pkg::FUNC_WRITE, 8'h7F, 8'h40, 3'd4,
                            8'h00, 8'h00, 8'h00, 8'h00, 8'hFF));
      send_command(make_cmd(FUNC_UNUSED, 8'h00, 8'h00, 3'd0,
                            8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_command(make_cmd(FUNC_UNUSED, 8'h10, 8'h22, 3'd3,
                            8'h01, 8'h02, 8'h03, 8'h04, 8'h05));
      send_command(make_cmd(sipf_pkg::FUNC_READ, 8'hFE, 8'hFF, 3'd0,
                            8'h00, 8'h00, 8'h00, 8'h00, 8'hFF));
      send_command(make_cmd(sipf_pkg::FUNC_RESET, 8'hF8, 8'h00, 3'd0,
                            8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

      sent = 0;
      while (sent < RANDOM_CMDS) begin
         tx_steady = ((sent % 60) >= 40);
         r = $urandom_range(0, 99);
         c.func        = (r < 5) ? FUNC_UNUSED :
                         (r < 50) ? sipf_pkg::FUNC_WRITE :
                         (r < 80) ? sipf_pkg::FUNC_READ : sipf_pkg::FUNC_RESET;
         c.target_id   = ($urandom_range(0, 9) == 0) ? 8'hFE : 8'($urandom_range(0, 254));
         c.reg_addr    = 8'($urandom_range(0, 255));
         c.data_count  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                     : 3'($urandom_range(0, 4));
         c.data_byte0  = 8'($urandom_range(0, 255));
         c.data_byte1  = 8'($urandom_range(0, 255));
         c.data_byte2  = 8'($urandom_range(0, 255));
         c.data_byte3  = 8'($urandom_range(0, 255));
         c.read_length = 8'($urandom_range(0, 255));
         send_command(c);
         if (c.func != FUNC_UNUSED) sent++;
      end
      tx_steady = 1'b0;
      req_push <= 1'b0;
      @(posedge clock);

      while (sb.wire_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.wire_q.size() != 0) begin
         $error("%0d expected bytes never arrived", sb.wire_q.size());
         sb.errors++;
      end
      $display("Framed %0d writes, %0d reads and %0d resets, dropped %0d undefined commands,",
               sb.n_write, sb.n_read, sb.n_reset, sb.n_dropped);
      $display("and checked %0d wire bytes across random idling and one long output stall.",
               sb.n_bytes);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
